### src/pipelined_cpu_with_forwarding_macros.svh
// assertion macros for the five-stage processor block
// no dependencies; included by the files that check their own logic
`ifndef PIPELINED_CPU_WITH_FORWARDING_MACROS_SVH
`define PIPELINED_CPU_WITH_FORWARDING_MACROS_SVH

// condition implies consequence in the same cycle
`define PCF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define PCF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/pcf_pkg.sv
// types, codes and decode helpers of the five-stage processor
// no dependencies; used by the top level by scoped names
package pcf_pkg;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_NOR  = 3'd1,
      OP_LW   = 3'd2,
      OP_SW   = 3'd3,
      OP_BEQ  = 3'd4,
      OP_JALR = 3'd5,
      OP_HALT = 3'd6,
      OP_NOOP = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      KIND_LOAD     = 2'd0,
      KIND_STEP     = 2'd1,
      KIND_READ_REG = 2'd2,
      KIND_READ_MEM = 2'd3
   } kind_type;

   // bits 31..25 of a program word carry nothing
   typedef logic [24:0] instr_type;

   localparam instr_type NOOP_INSTR = {OP_NOOP, 22'd0};

   typedef struct packed {
      instr_type   instr;
      logic [15:0] pcp1;
   } fd_type;

   typedef struct packed {
      instr_type   instr;
      logic [15:0] pcp1;
      logic [31:0] val_a;
      logic [31:0] val_b;
      logic [31:0] offset;
   } de_type;

   typedef struct packed {
      instr_type   instr;
      logic [15:0] target;
      logic        eq;
      logic [31:0] alu;
      logic [31:0] val_b;
   } em_type;

   typedef struct packed {
      instr_type   instr;
      logic [31:0] data;
   } wb_type;

   // one finished item before the result register
   typedef struct packed {
      logic [15:0] pc;
      logic        halted;
      logic [31:0] cycles;
      logic        reg_write;
      logic [2:0]  reg_index;
      logic        store_write;
      logic [15:0] store_address;
      logic [31:0] result_word;
      logic        read_mem;
   } item_type;

   function automatic op_type op_of(instr_type i);
      return op_type'(i[24:22]);
   endfunction

   function automatic logic [2:0] ra_of(instr_type i);
      return i[21:19];
   endfunction

   function automatic logic [2:0] rb_of(instr_type i);
      return i[18:16];
   endfunction

   function automatic logic [2:0] dst_of(instr_type i);
      return i[2:0];
   endfunction

   function automatic logic [31:0] sext16(instr_type i);
      return {{16{i[15]}}, i[15:0]};
   endfunction

   function automatic logic is_alu(instr_type i);
      return (op_of(i) == OP_ADD) || (op_of(i) == OP_NOR);
   endfunction

   // registers named in the ra and rb fields of add, nor, lw, sw and beq
   function automatic logic uses_reg(instr_type i, logic [2:0] r);
      logic src;
      src = (op_of(i) == OP_ADD) || (op_of(i) == OP_NOR) || (op_of(i) == OP_LW) ||
            (op_of(i) == OP_SW) || (op_of(i) == OP_BEQ);
      return src && ((ra_of(i) == r) || (rb_of(i) == r));
   endfunction

endpackage

### src/pcf_if.sv
// valid/ready channels of the five-stage processor block
// no dependencies
interface pcf_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [15:0]        address;
   logic signed [31:0] word;

   modport source (output valid, kind, address, word, input ready);
   modport sink (input valid, kind, address, word, output ready);
endinterface

interface pcf_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        pc;
   logic               halted;
   logic [31:0]        cycles;
   logic               reg_write;
   logic [2:0]         reg_index;
   logic               store_write;
   logic [15:0]        store_address;
   logic signed [31:0] result_word;

   modport source (output valid, pc, halted, cycles, reg_write, reg_index, store_write,
                   store_address, result_word, input ready);
   modport sink (input valid, pc, halted, cycles, reg_write, reg_index, store_write,
                 store_address, result_word, output ready);
endinterface

### src/pipelined_cpu_with_forwarding.sv
// channel   dir   payload
// req       in    kind, address, word
// rsp       out   pc, halted, cycles, reg_write, reg_index, store_write,
//                 store_address, result_word
// one item a cycle unless rsp stalls; a step moves all five stages once unless halted.
// results pass the item and result registers, as the data memory read port needs.
// synchronous reset clears pc, stages, register file and counters; memories keep data.
// a stalled rsp holds both item registers; req then waits once both are full.
// depends on pcf_pkg, pcf_if and pipelined_cpu_with_forwarding_macros.svh
`include "pipelined_cpu_with_forwarding_macros.svh"

module pipelined_cpu_with_forwarding #(
   parameter int MEM_DEPTH = 1024
) (
   input logic         clock,
   input logic         reset,
   pcf_req_if.sink     req,
   pcf_rsp_if.source   rsp
);

   localparam int ADDR_W = $clog2(MEM_DEPTH);

   // architectural state
   logic [15:0]            pc_ff, pc_in;
   logic [31:0]            cyc_ff, cyc_in;
   logic [31:0]            rf_ff [8];
   pcf_pkg::fd_type        fd_ff, fd_in;
   pcf_pkg::de_type        de_ff, de_in;
   pcf_pkg::em_type        em_ff, em_in;
   pcf_pkg::wb_type        mw_ff, mw_in;
   pcf_pkg::wb_type        we_ff, we_in;

   // memories and registered read data
   logic [31:0]            imem [MEM_DEPTH];
   logic [31:0]            dmem [MEM_DEPTH];
   logic [31:0]            imem_rd_ff;
   logic [31:0]            dmem_a_ff;
   logic [31:0]            dmem_b_ff;

   // item pipeline
   pcf_pkg::item_type      s1_ff, s1_in;
   logic                   s1_v_ff;
   pcf_pkg::item_type      out_ff, out_in;
   logic                   out_v_ff;

   logic                   acc, adv, step, mw_halt, ld_stall, taken;
   pcf_pkg::kind_type      kind;
   logic [31:0]            fa, fb, b2;
   pcf_pkg::op_type        de_op, em_op, mw_op;
   logic                   rw;
   logic [2:0]             ri;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_wa;
   logic [31:0]            mem_wd;
   logic [ADDR_W-1:0]      pc_idx_nx, alu_idx_nx;

   // forwarding, newest stage first
   function automatic logic [31:0] fwd(pcf_pkg::em_type em, pcf_pkg::wb_type mw,
                                       pcf_pkg::wb_type we, logic [2:0] r,
                                       logic [31:0] dflt);
      logic [31:0] v;
      v = dflt;
      if (pcf_pkg::is_alu(em.instr) && pcf_pkg::dst_of(em.instr) == r) begin
         v = em.alu;
      end else if (pcf_pkg::is_alu(mw.instr) && pcf_pkg::dst_of(mw.instr) == r) begin
         v = mw.data;
      end else if (pcf_pkg::op_of(mw.instr) == pcf_pkg::OP_LW &&
                   pcf_pkg::rb_of(mw.instr) == r) begin
         v = mw.data;
      end else if (pcf_pkg::is_alu(we.instr) && pcf_pkg::dst_of(we.instr) == r) begin
         v = we.data;
      end else if (pcf_pkg::op_of(we.instr) == pcf_pkg::OP_LW &&
                   pcf_pkg::rb_of(we.instr) == r) begin
         v = we.data;
      end
      return v;
   endfunction

   // handshake
   assign adv       = !out_v_ff || rsp.ready;
   assign req.ready = !reset && (!s1_v_ff || adv);
   assign acc       = req.valid && req.ready;
   assign kind      = pcf_pkg::kind_type'(req.kind);
   assign mw_halt   = pcf_pkg::op_of(mw_ff.instr) == pcf_pkg::OP_HALT;
   assign step      = acc && (kind == pcf_pkg::KIND_STEP) && !mw_halt;

   assign de_op = pcf_pkg::op_of(de_ff.instr);
   assign em_op = pcf_pkg::op_of(em_ff.instr);
   assign mw_op = pcf_pkg::op_of(mw_ff.instr);

   assign ld_stall = (de_op == pcf_pkg::OP_LW) &&
                     pcf_pkg::uses_reg(fd_ff.instr, pcf_pkg::rb_of(de_ff.instr));
   assign taken    = (em_op == pcf_pkg::OP_BEQ) && em_ff.eq;

   // execute operands
   assign fa = fwd(em_ff, mw_ff, we_ff, pcf_pkg::ra_of(de_ff.instr), de_ff.val_a);
   assign fb = fwd(em_ff, mw_ff, we_ff, pcf_pkg::rb_of(de_ff.instr), de_ff.val_b);
   assign b2 = (pcf_pkg::is_alu(de_ff.instr) || de_op == pcf_pkg::OP_BEQ) ? fb
                                                                          : de_ff.offset;

   // retiring write
   always_comb begin
      rw = 1'b0;
      ri = 3'd0;
      if (mw_op == pcf_pkg::OP_LW) begin
         rw = 1'b1;
         ri = pcf_pkg::rb_of(mw_ff.instr);
      end else if (pcf_pkg::is_alu(mw_ff.instr)) begin
         rw = 1'b1;
         ri = pcf_pkg::dst_of(mw_ff.instr);
      end
   end

   // next stage contents for one processor cycle
   always_comb begin
      pc_in  = pc_ff;
      cyc_in = cyc_ff;
      fd_in  = fd_ff;
      de_in  = de_ff;
      em_in  = em_ff;
      mw_in  = mw_ff;
      we_in  = we_ff;
      if (step) begin
         cyc_in = cyc_ff + 32'd1;
         // fetch
         fd_in.instr = imem_rd_ff[24:0];
         fd_in.pcp1  = pc_ff + 16'd1;
         pc_in       = pc_ff + 16'd1;
         // decode with load-use bubble
         if (ld_stall) begin
            de_in.instr = pcf_pkg::NOOP_INSTR;
            pc_in       = pc_ff;
            fd_in       = fd_ff;
         end else begin
            de_in.instr  = fd_ff.instr;
            de_in.val_a  = rf_ff[pcf_pkg::ra_of(fd_ff.instr)];
            de_in.val_b  = rf_ff[pcf_pkg::rb_of(fd_ff.instr)];
            de_in.pcp1   = fd_ff.pcp1;
            de_in.offset = pcf_pkg::sext16(fd_ff.instr);
         end
         // execute
         em_in.target = de_ff.pcp1 + de_ff.offset[15:0];
         em_in.eq     = (fa == b2);
         em_in.alu    = (de_op == pcf_pkg::OP_NOR) ? ~(fa | b2) : fa + b2;
         em_in.val_b  = fb;
         em_in.instr  = de_ff.instr;
         // memory
         if (em_op == pcf_pkg::OP_SW) begin
            mw_in.data = em_ff.val_b;
         end else if (em_op == pcf_pkg::OP_LW) begin
            mw_in.data = dmem_a_ff;
         end else if (pcf_pkg::is_alu(em_ff.instr)) begin
            mw_in.data = em_ff.alu;
         end
         if (taken) begin
            pc_in       = em_ff.target;
            fd_in.instr = pcf_pkg::NOOP_INSTR;
            de_in.instr = pcf_pkg::NOOP_INSTR;
            em_in.instr = pcf_pkg::NOOP_INSTR;
         end
         mw_in.instr = em_ff.instr;
         // writeback
         we_in = mw_ff;
      end
   end

   // result of the accepted item
   always_comb begin
      s1_in               = '0;
      s1_in.pc            = pc_in;
      s1_in.halted        = pcf_pkg::op_of(mw_in.instr) == pcf_pkg::OP_HALT;
      s1_in.cycles        = cyc_in;
      case (kind)
         pcf_pkg::KIND_LOAD: begin
            s1_in.result_word = req.word;
         end
         pcf_pkg::KIND_STEP: begin
            if (step) begin
               s1_in.reg_write = rw;
               s1_in.reg_index = ri;
               if (em_op == pcf_pkg::OP_SW) begin
                  s1_in.store_write   = 1'b1;
                  s1_in.store_address = 16'(em_ff.alu[ADDR_W-1:0]);
                  s1_in.result_word   = em_ff.val_b;
               end
               if (rw) begin
                  s1_in.result_word = mw_ff.data;
               end
            end
         end
         pcf_pkg::KIND_READ_REG: begin
            s1_in.result_word = rf_ff[req.address[2:0]];
         end
         pcf_pkg::KIND_READ_MEM: begin
            s1_in.read_mem = 1'b1;
         end
         default: begin
            s1_in.read_mem = 1'b0;
         end
      endcase
   end

   // memory write port and next read addresses
   assign mem_we = (acc && kind == pcf_pkg::KIND_LOAD) || (step && em_op == pcf_pkg::OP_SW);
   assign mem_wa = (kind == pcf_pkg::KIND_LOAD) ? req.address[ADDR_W-1:0]
                                                : em_ff.alu[ADDR_W-1:0];
   assign mem_wd = (kind == pcf_pkg::KIND_LOAD) ? req.word : em_ff.val_b;
   assign pc_idx_nx  = pc_in[ADDR_W-1:0];
   assign alu_idx_nx = em_in.alu[ADDR_W-1:0];

   // instruction memory, read data holds the word at pc, except just after reset
   always_ff @(posedge clock) begin
      if (acc && kind == pcf_pkg::KIND_LOAD) begin
         imem[req.address[ADDR_W-1:0]] <= req.word;
      end
      if (acc && kind == pcf_pkg::KIND_LOAD && req.address[ADDR_W-1:0] == pc_idx_nx) begin
         imem_rd_ff <= req.word;
      end else begin
         imem_rd_ff <= imem[pc_idx_nx];
      end
   end

   // data memory, port a follows the ex/mem address, port b serves read items
   always_ff @(posedge clock) begin
      if (mem_we) begin
         dmem[mem_wa] <= mem_wd;
      end
      if (mem_we && mem_wa == alu_idx_nx) begin
         dmem_a_ff <= mem_wd;
      end else begin
         dmem_a_ff <= dmem[alu_idx_nx];
      end
      if (acc) begin
         dmem_b_ff <= dmem[req.address[ADDR_W-1:0]];
      end
   end

   // processor state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= '0;
         cyc_ff <= '0;
         fd_ff  <= '{instr: pcf_pkg::NOOP_INSTR, default: '0};
         de_ff  <= '{instr: pcf_pkg::NOOP_INSTR, default: '0};
         em_ff  <= '{instr: pcf_pkg::NOOP_INSTR, default: '0};
         mw_ff  <= '{instr: pcf_pkg::NOOP_INSTR, default: '0};
         we_ff  <= '{instr: pcf_pkg::NOOP_INSTR, default: '0};
         for (int i = 0; i < 8; i++) begin
            rf_ff[i] <= '0;
         end
      end else begin
         pc_ff  <= pc_in;
         cyc_ff <= cyc_in;
         fd_ff  <= fd_in;
         de_ff  <= de_in;
         em_ff  <= em_in;
         mw_ff  <= mw_in;
         we_ff  <= we_in;
         if (step && rw) begin
            rf_ff[ri] <= mw_ff.data;
         end
      end
   end

   // item register and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (acc) begin
            s1_v_ff <= 1'b1;
         end else if (adv) begin
            s1_v_ff <= 1'b0;
         end
         if (adv) begin
            out_v_ff <= s1_v_ff;
         end
      end
   end

   // read items take their word from the data memory read port
   always_comb begin
      out_in = s1_ff;
      if (s1_ff.read_mem) begin
         out_in.result_word = dmem_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_ff <= s1_in;
      end
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid         = out_v_ff;
   assign rsp.pc            = out_ff.pc;
   assign rsp.halted        = out_ff.halted;
   assign rsp.cycles        = out_ff.cycles;
   assign rsp.reg_write     = out_ff.reg_write;
   assign rsp.reg_index     = out_ff.reg_index;
   assign rsp.store_write   = out_ff.store_write;
   assign rsp.store_address = out_ff.store_address;
   assign rsp.result_word   = out_ff.result_word;

   // checks
   `PCF_ASSERT_NEXT(a_halt_freezes, clock, reset, mw_halt,
      ($stable(pc_ff) && $stable(cyc_ff)), "state moved while halted")
   `PCF_ASSERT_NEXT(a_stall_holds_pc, clock, reset, (step && ld_stall && !taken),
      (pc_ff == $past(pc_ff)), "pc advanced during load-use bubble")
   `PCF_ASSERT_NOW(a_store_in_range, clock, reset, (s1_v_ff && s1_ff.store_write),
      (32'(s1_ff.store_address) < MEM_DEPTH), "store address beyond memory")
   `PCF_ASSERT_NOW(a_one_flow, clock, reset, (s1_v_ff && out_v_ff && !rsp.ready),
      (!req.ready), "item taken with both registers full")

endmodule
